// ===== rtl/core/sccb_pkg.sv =====
// Shared command codes, phase counts and types for the SCCB bit-level master.
`timescale 1ns / 1ps

package sccb_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_NOACK = 3'd5
    } t_cmd;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd100;

    localparam logic [4:0] LEN_START = 5'd4;
    localparam logic [4:0] LEN_STOP  = 5'd3;
    localparam logic [4:0] LEN_NOACK = 5'd4;
    localparam logic [4:0] LEN_WRITE = 5'd28;
    localparam logic [4:0] LEN_READ  = 5'd25;

    // write byte: 24 bit phases, then wait, release, ack clock high, clock low
    localparam logic [4:0] WR_BIT_PHASES = 5'd24;
    localparam logic [4:0] WR_RELEASE    = 5'd25;
    localparam logic [4:0] WR_ACK_HIGH   = 5'd26;
    localparam logic [4:0] WR_ACK_LOW    = 5'd27;

    localparam logic [0:0] ADDR_PHASE_TICKS = 1'b0;

    function automatic logic [4:0] op_length(input t_cmd op);
        logic [4:0] len;
        case (op)
            CMD_START: len = LEN_START;
            CMD_STOP:  len = LEN_STOP;
            CMD_NOACK: len = LEN_NOACK;
            CMD_WRITE: len = LEN_WRITE;
            CMD_READ:  len = LEN_READ;
            default:   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/sccb_bus_master.sv =====
// Top level of the SCCB bit-level master: phase sequencer, pin state and APB register.
`timescale 1ns / 1ps

// Each input item is one bus timing tick and yields exactly one result item with the
// pin levels and status after that tick. One item is taken per clock cycle: the whole
// tick update (phase counter compare, phase entry levels, end-of-phase sampling) sits
// between the state registers, and the registered result can wait for the sink while
// the next item is held back. A command is taken only while idle; start lasts
// 4 phases, stop 3, no-ack 4, write byte 28 and read byte 25, each phase_ticks ticks
// long (0 acts as 1). phase_ticks sits at address 0 of the APB port, reset 100.
module sccb_bus_master
    import sccb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_write_byte,
    input  logic        i_data_pin_in,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_clock_pin,
    output logic        o_data_pin_out,
    output logic        o_data_pin_enable,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_ack_ok,
    output logic [7:0]  o_read_result
);

    logic [15:0] r_phase_ticks;
    t_cmd        r_op, n_op;
    logic [4:0]  r_phase, n_phase;
    logic [15:0] r_tick, n_tick;
    logic [1:0]  r_sub, n_sub;
    logic [7:0]  r_shift, n_shift;
    logic        r_clk_lvl, n_clk_lvl;
    logic        r_dat_lvl, n_dat_lvl;
    logic        r_drv_en, n_drv_en;
    logic        r_ack, n_ack;
    logic [7:0]  r_rd_byte, n_rd_byte;
    logic        r_done, n_done;
    logic        r_out_valid;

    logic        w_in_acc;
    logic        w_cfg_wr;
    logic        w_do_enter;
    logic        w_phase_end;

    assign pready      = 1'b1;
    assign w_cfg_wr    = psel & penable & pwrite & pready;
    assign prdata      = (paddr == ADDR_PHASE_TICKS) ? {16'd0, r_phase_ticks} : 32'd0;

    assign o_in_ready  = ~r_out_valid | i_out_ready;
    assign w_in_acc    = i_in_valid & o_in_ready;
    assign w_phase_end = ({1'b0, r_tick} + 17'd1) >= {1'b0, r_phase_ticks};

    always_comb begin
        n_op      = r_op;
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_sub     = r_sub;
        n_shift   = r_shift;
        n_clk_lvl = r_clk_lvl;
        n_dat_lvl = r_dat_lvl;
        n_drv_en  = r_drv_en;
        n_ack     = r_ack;
        n_rd_byte = r_rd_byte;
        n_done    = 1'b0;
        w_do_enter = 1'b0;

        if (r_op == CMD_NONE) begin
            if (i_cmd inside {CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_NOACK}) begin
                n_op    = t_cmd'(i_cmd);
                n_phase = 5'd0;
                n_tick  = 16'd0;
                // read counts sub-phases from phase 1
                n_sub   = (t_cmd'(i_cmd) == CMD_READ) ? 2'd2 : 2'd0;
                if (t_cmd'(i_cmd) == CMD_WRITE) begin
                    n_shift = i_write_byte;
                end else if (t_cmd'(i_cmd) == CMD_READ) begin
                    n_shift = 8'd0;
                end
                w_do_enter = 1'b1;
            end
        end else if (w_phase_end) begin
            n_tick = 16'd0;
            // end-of-phase sampling
            if (r_op == CMD_WRITE && r_phase == WR_ACK_HIGH) begin
                n_ack = ~i_data_pin_in;
            end else if (r_op == CMD_READ && r_phase != 5'd0 && r_sub == 2'd1) begin
                n_shift = {r_shift[6:0], i_data_pin_in};
            end
            n_phase = r_phase + 5'd1;
            n_sub   = (r_sub == 2'd2) ? 2'd0 : r_sub + 2'd1;
            if (n_phase == op_length(r_op)) begin
                if (r_op == CMD_WRITE) begin
                    n_drv_en = 1'b1;
                end
                if (r_op == CMD_READ) begin
                    n_rd_byte = n_shift;
                end
                n_op    = CMD_NONE;
                n_phase = 5'd0;
                n_done  = 1'b1;
            end else begin
                w_do_enter = 1'b1;
            end
        end else begin
            n_tick = r_tick + 16'd1;
        end

        // levels set on the first tick of a phase
        if (w_do_enter) begin
            case (n_op)
                CMD_START: begin
                    case (n_phase)
                        5'd0: begin
                            n_drv_en  = 1'b1;
                            n_dat_lvl = 1'b1;
                        end
                        5'd1:    n_clk_lvl = 1'b1;
                        5'd2:    n_dat_lvl = 1'b0;
                        default: n_clk_lvl = 1'b0;
                    endcase
                end
                CMD_STOP: begin
                    case (n_phase)
                        5'd0: begin
                            n_drv_en  = 1'b1;
                            n_dat_lvl = 1'b0;
                        end
                        5'd1:    n_clk_lvl = 1'b1;
                        default: n_dat_lvl = 1'b1;
                    endcase
                end
                CMD_NOACK: begin
                    case (n_phase)
                        5'd0: begin
                            n_drv_en  = 1'b0;
                            n_dat_lvl = 1'b1;
                        end
                        5'd1:    n_clk_lvl = 1'b1;
                        5'd2:    n_clk_lvl = 1'b0;
                        default: n_dat_lvl = 1'b0;
                    endcase
                end
                CMD_WRITE: begin
                    if (n_phase < WR_BIT_PHASES) begin
                        case (n_sub)
                            2'd0: begin
                                if (n_phase == 5'd0) begin
                                    n_drv_en = 1'b1;
                                end
                                n_dat_lvl = n_shift[7];
                                n_shift   = {n_shift[6:0], 1'b0};
                            end
                            2'd1:    n_clk_lvl = 1'b1;
                            default: n_clk_lvl = 1'b0;
                        endcase
                    end else if (n_phase == WR_RELEASE) begin
                        n_drv_en = 1'b0;
                    end else if (n_phase == WR_ACK_HIGH) begin
                        n_clk_lvl = 1'b1;
                    end else if (n_phase == WR_ACK_LOW) begin
                        n_clk_lvl = 1'b0;
                    end
                end
                CMD_READ: begin
                    if (n_phase == 5'd0) begin
                        n_drv_en = 1'b0;
                    end else if (n_sub == 2'd1) begin
                        n_clk_lvl = 1'b1;
                    end else if (n_sub == 2'd2) begin
                        n_clk_lvl = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (w_cfg_wr && paddr == ADDR_PHASE_TICKS) begin
            r_phase_ticks <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= CMD_NONE;
            r_phase     <= 5'd0;
            r_tick      <= 16'd0;
            r_sub       <= 2'd0;
            r_shift     <= 8'd0;
            r_clk_lvl   <= 1'b1;
            r_dat_lvl   <= 1'b1;
            r_drv_en    <= 1'b1;
            r_ack       <= 1'b0;
            r_rd_byte   <= 8'd0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_op      <= n_op;
                r_phase   <= n_phase;
                r_tick    <= n_tick;
                r_sub     <= n_sub;
                r_shift   <= n_shift;
                r_clk_lvl <= n_clk_lvl;
                r_dat_lvl <= n_dat_lvl;
                r_drv_en  <= n_drv_en;
                r_ack     <= n_ack;
                r_rd_byte <= n_rd_byte;
                r_done    <= n_done;
            end
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the state registers hold the last item's result until the next item is taken
    assign o_out_valid       = r_out_valid;
    assign o_clock_pin       = r_clk_lvl;
    assign o_data_pin_out    = r_dat_lvl;
    assign o_data_pin_enable = r_drv_en;
    assign o_busy_res        = (r_op != CMD_NONE);
    assign o_done_res        = r_done;
    assign o_ack_ok          = r_ack;
    assign o_read_result     = r_rd_byte;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the SCCB bit-level master: tick items in, pin state items out.
`timescale 1ns / 1ps

module tb_top;
    import sccb_pkg::*;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] wbyte;
        logic       din;
    } t_tick;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       sda_en;
        logic       busy;
        logic       done;
        logic       ack;
        logic [7:0] rdata;
    } t_pins;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = ADDR_PHASE_TICKS;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  in_cmd = CMD_NONE;
    logic [7:0]  in_wbyte = '0;
    logic        in_din = 1'b0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    logic        o_clock_pin;
    logic        o_data_pin_out;
    logic        o_data_pin_enable;
    logic        o_busy_res;
    logic        o_done_res;
    logic        o_ack_ok;
    logic [7:0]  o_read_result;

    sccb_bus_master uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (in_cmd),
        .i_write_byte      (in_wbyte),
        .i_data_pin_in     (in_din),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_clock_pin       (o_clock_pin),
        .o_data_pin_out    (o_data_pin_out),
        .o_data_pin_enable (o_data_pin_enable),
        .o_busy_res        (o_busy_res),
        .o_done_res        (o_done_res),
        .o_ack_ok          (o_ack_ok),
        .o_read_result     (o_read_result)
    );

    always #4 i_clk = ~i_clk;

    t_tick tick_q[$];
    t_pins pins_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_cnt = 0;
    int acc_cnt = 0;
    int chk_cnt = 0;
    int cmd_cnt = 0;
    int cfg_cnt = 0;

    logic holdoff_go = 1'b0;
    logic holdoff_done = 1'b0;
    int   holdoff_cyc = 0;
    wire  holding = holdoff_go && !holdoff_done;

    // bus master shadow state
    logic [15:0] cfg_ticks = PHASE_TICKS_RST;
    t_cmd        cur_op = CMD_NONE;
    logic [4:0]  phase_idx = '0;
    logic [15:0] tick_cnt = '0;
    logic [7:0]  shreg = '0;
    logic        scl = 1'b1;
    logic        sda = 1'b1;
    logic        sda_en = 1'b1;
    logic        ack_r = 1'b0;
    logic [7:0]  rd_byte = '0;

    function automatic int phase_count(input t_cmd op);
        case (op)
            CMD_START: return int'(LEN_START);
            CMD_STOP:  return int'(LEN_STOP);
            CMD_NOACK: return int'(LEN_NOACK);
            CMD_WRITE: return int'(LEN_WRITE);
            CMD_READ:  return int'(LEN_READ);
            default:   return 0;
        endcase
    endfunction

    task automatic set_phase_levels();
        case (cur_op)
            CMD_START: begin
                case (phase_idx)
                    5'd0: begin
                        sda_en = 1'b1;
                        sda = 1'b1;
                    end
                    5'd1: scl = 1'b1;
                    5'd2: sda = 1'b0;
                    default: scl = 1'b0;
                endcase
            end
            CMD_STOP: begin
                case (phase_idx)
                    5'd0: begin
                        sda_en = 1'b1;
                        sda = 1'b0;
                    end
                    5'd1: scl = 1'b1;
                    default: sda = 1'b1;
                endcase
            end
            CMD_NOACK: begin
                case (phase_idx)
                    5'd0: begin
                        sda_en = 1'b0;
                        sda = 1'b1;
                    end
                    5'd1: scl = 1'b1;
                    5'd2: scl = 1'b0;
                    default: sda = 1'b0;
                endcase
            end
            CMD_WRITE: begin
                if (phase_idx < WR_BIT_PHASES) begin
                    case (phase_idx % 3)
                        0: begin
                            if (phase_idx == 5'd0) sda_en = 1'b1;
                            sda = shreg[7];
                            shreg = {shreg[6:0], 1'b0};
                        end
                        1: scl = 1'b1;
                        default: scl = 1'b0;
                    endcase
                end else if (phase_idx == WR_RELEASE) begin
                    sda_en = 1'b0;
                end else if (phase_idx == WR_ACK_HIGH) begin
                    scl = 1'b1;
                end else if (phase_idx == WR_ACK_LOW) begin
                    scl = 1'b0;
                end
            end
            CMD_READ: begin
                if (phase_idx == 5'd0) begin
                    sda_en = 1'b0;
                end else begin
                    case ((phase_idx - 5'd1) % 3)
                        1: scl = 1'b1;
                        2: scl = 1'b0;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_tick(input t_tick t, output t_pins r);
        logic fin;
        fin = 1'b0;
        if (cur_op == CMD_NONE) begin
            if (t.cmd >= CMD_START && t.cmd <= CMD_NOACK) begin
                cur_op = t_cmd'(t.cmd);
                phase_idx = '0;
                tick_cnt = '0;
                if (t.cmd == CMD_WRITE) shreg = t.wbyte;
                else if (t.cmd == CMD_READ) shreg = '0;
                set_phase_levels();
                cmd_cnt++;
            end
        end else if ({1'b0, tick_cnt} + 17'd1 >= {1'b0, cfg_ticks}) begin
            tick_cnt = '0;
            // end-of-phase sampling
            if (cur_op == CMD_WRITE && phase_idx == WR_ACK_HIGH) begin
                ack_r = ~t.din;
            end else if (cur_op == CMD_READ && phase_idx >= 5'd1
                         && ((phase_idx - 5'd1) % 3) == 1) begin
                shreg = {shreg[6:0], t.din};
            end
            phase_idx++;
            if (phase_idx >= phase_count(cur_op)) begin
                if (cur_op == CMD_WRITE) sda_en = 1'b1;
                if (cur_op == CMD_READ) rd_byte = shreg;
                cur_op = CMD_NONE;
                phase_idx = '0;
                fin = 1'b1;
            end else begin
                set_phase_levels();
            end
        end else begin
            tick_cnt++;
        end
        r = '{scl, sda, sda_en, cur_op != CMD_NONE, fin, ack_r, rd_byte};
    endtask

    // driver
    always @(posedge i_clk) begin : drv
        t_pins want;
        t_tick nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_tick('{in_cmd, in_wbyte, in_din}, want);
                pins_q.push_back(want);
                acc_cnt++;
            end
            if (!in_valid || o_in_ready) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = tick_q.pop_front();
                    in_cmd <= nxt.cmd;
                    in_wbyte <= nxt.wbyte;
                    in_din <= nxt.din;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin : mon
        t_pins want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pins_q.size() == 0) begin
                    $error("result item with no expectation pending");
                    err_cnt++;
                end else begin
                    want = pins_q.pop_front();
                    check_field("clock_pin", want.scl, o_clock_pin);
                    check_field("data_pin_out", want.sda, o_data_pin_out);
                    check_field("data_pin_enable", want.sda_en, o_data_pin_enable);
                    check_field("busy_res", want.busy, o_busy_res);
                    check_field("done_res", want.done, o_done_res);
                    check_field("ack_ok", want.ack, o_ack_ok);
                    check_field("read_result", want.rdata, o_read_result);
                    chk_cnt++;
                end
            end
            out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (holding) begin
            if (holdoff_cyc == 400) holdoff_done <= 1'b1;
            else holdoff_cyc <= holdoff_cyc + 1;
        end
    end

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_PHASE_TICKS;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_phase_ticks(input logic [15:0] val);
        logic [31:0] rd;
        apb_access(1'b1, {16'h0, val}, rd);
        cfg_ticks = val;
        cfg_cnt++;
        apb_access(1'b0, '0, rd);
        if (rd != {16'h0, val}) begin
            $error("phase_ticks readback: expected %0d, got %0d", val, rd);
            err_cnt++;
        end
    endtask

    // checked at the falling edge, once driver and monitor updates have settled
    task automatic wait_drained();
        while (tick_q.size() != 0 || in_valid || pins_q.size() != 0) @(negedge i_clk);
    endtask

    // drain, then tick the bus master until its sequence has finished
    task automatic wait_bus_idle();
        wait_drained();
        while (cur_op != CMD_NONE) begin
            tick_q.push_back('{CMD_NONE, 8'($urandom), 1'($urandom)});
            wait_drained();
        end
    endtask

    // command item followed by gap filler ticks; din_mode 0 low, 1 high, 2 random
    task automatic push_seq(input logic [2:0] cmd, input logic [7:0] wb, input int gap,
                            input int din_mode, input bit noisy);
        t_tick t;
        logic d;
        for (int i = 0; i <= gap; i++) begin
            d = (din_mode == 2) ? 1'($urandom) : 1'(din_mode);
            if (i == 0) t = '{cmd, wb, d};
            else if (noisy && $urandom_range(3) == 0) t = '{3'($urandom), 8'($urandom), d};
            else t = '{CMD_NONE, 8'($urandom), d};
            tick_q.push_back(t);
        end
    endtask

    function automatic int seq_ticks(input logic [2:0] cmd);
        int pt;
        pt = (cfg_ticks == 16'd0) ? 1 : int'(cfg_ticks);
        return phase_count(t_cmd'(cmd)) * pt;
    endfunction

    initial begin : stim
        int pt_list[6];
        int n_pushed;
        int r;
        int gap;
        logic [2:0] c;
        logic [31:0] rd;
        pt_list = '{1, 2, 3, 1, 4, 0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset phase length
        apb_access(1'b0, '0, rd);
        if (rd != {16'h0, PHASE_TICKS_RST}) begin
            $error("phase_ticks reset: expected %0d, got %0d", PHASE_TICKS_RST, rd);
            err_cnt++;
        end
        push_seq(CMD_STOP, 8'hFF, seq_ticks(CMD_STOP), 2, 1'b0);
        wait_bus_idle();

        // directed, one tick per phase
        set_phase_ticks(16'd1);
        push_seq(CMD_START, 8'h00, seq_ticks(CMD_START), 2, 1'b0);
        push_seq(CMD_WRITE, 8'hFF, seq_ticks(CMD_WRITE), 0, 1'b0);
        push_seq(CMD_WRITE, 8'h00, seq_ticks(CMD_WRITE), 1, 1'b0);
        push_seq(CMD_READ, 8'h5A, seq_ticks(CMD_READ), 1, 1'b0);
        push_seq(CMD_WRITE, 8'hA5, seq_ticks(CMD_WRITE), 2, 1'b0);
        push_seq(CMD_READ, 8'hFF, seq_ticks(CMD_READ), 0, 1'b0);
        push_seq(CMD_READ, 8'h00, seq_ticks(CMD_READ), 2, 1'b0);
        push_seq(CMD_NOACK, 8'h00, seq_ticks(CMD_NOACK), 2, 1'b0);
        push_seq(CMD_WRITE, 8'h81, seq_ticks(CMD_WRITE), 0, 1'b0);
        // commands offered while busy are dropped
        tick_q.push_back('{CMD_WRITE, 8'h3C, 1'b1});
        for (int i = 0; i < 28; i++) tick_q.push_back('{3'($urandom_range(1, 7)), 8'hC3, 1'b1});
        push_seq(CMD_STOP, 8'h00, seq_ticks(CMD_STOP), 2, 1'b0);
        push_seq(3'd6, 8'hFF, 1, 2, 1'b0);
        push_seq(3'd7, 8'h00, 1, 2, 1'b0);
        push_seq(CMD_NONE, 8'h00, 1, 2, 1'b0);
        push_seq(CMD_START, 8'h00, seq_ticks(CMD_START) + 1, 2, 1'b0);
        wait_bus_idle();

        // zero phase length acts as one
        set_phase_ticks(16'd0);
        push_seq(CMD_START, 8'h00, seq_ticks(CMD_START), 2, 1'b0);
        push_seq(CMD_WRITE, 8'h3C, seq_ticks(CMD_WRITE), 0, 1'b0);
        push_seq(CMD_READ, 8'h00, seq_ticks(CMD_READ), 2, 1'b0);
        wait_bus_idle();

        // longest phase length, idle ticks only
        set_phase_ticks(16'hFFFF);
        push_seq(CMD_NONE, 8'h00, 3, 2, 1'b0);
        wait_bus_idle();

        // random command streams under the idling profiles
        for (int k = 0; k < 6; k++) begin
            set_phase_ticks(pt_list[k] == 0 ? 16'($urandom_range(1, 5)) : 16'(pt_list[k]));
            case (k % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 75;
                end
                default: begin
                    send_idle_pct = 24;
                    recv_stall_pct = 24;
                end
            endcase
            if (k == 4) holdoff_go = 1'b1;
            n_pushed = 0;
            while (n_pushed < 50) begin
                r = $urandom_range(99);
                if (r < 5) begin
                    c = 3'($urandom_range(6, 7));
                    gap = $urandom_range(0, 2);
                end else begin
                    c = 3'($urandom_range(1, 5));
                    if (r < 78) gap = seq_ticks(c) + $urandom_range(0, 3);
                    else gap = $urandom_range(0, seq_ticks(c));
                end
                push_seq(c, 8'($urandom), gap, 2, $urandom_range(2) == 0);
                n_pushed += gap + 1;
                if (k == 1 && n_pushed >= 25 && n_pushed - gap - 1 < 25) wait_drained();
            end
            wait_bus_idle();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d tick items, %0d results checked, %0d bus commands run,",
                 acc_cnt, chk_cnt, cmd_cnt);
        $display("%0d phase length settings including 0, 1 and 65535.", cfg_cnt);
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("Timeout waiting for results");
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sccb_pkg.sv
rtl/core/sccb_bus_master.sv
bench/tb_top.sv
